// ===== hw/rtl/scfp_pkg.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// scfp_pkg
// Shared types and constants for the serial command frame parser.
// ---------------------------------------------------------------------------
package scfp_pkg;

    localparam int BUFFER_BYTES_DEF = 64;
    localparam int NUM_HANDLERS     = 8;

    localparam logic [7:0] FIELD_SEP_RST   = 8'd44;
    localparam logic [7:0] COMMAND_SEP_RST = 8'd59;

    localparam logic [7:0] CHAR_LF    = 8'd10;
    localparam logic [7:0] CHAR_CR    = 8'd13;
    localparam logic [7:0] CHAR_TAB   = 8'd9;
    localparam logic [7:0] CHAR_SPACE = 8'd32;
    localparam logic [7:0] CHAR_PLUS  = 8'd43;
    localparam logic [7:0] CHAR_MINUS = 8'd45;
    localparam logic [7:0] CHAR_ZERO  = 8'd48;
    localparam logic [7:0] CHAR_NINE  = 8'd57;

    localparam logic [15:0] MAG_LIMIT = 16'd32768;
    localparam logic [15:0] POS_MAX   = 16'd32767;

    localparam int APB_ADDR_W = 4;

    typedef enum logic [1:0] {
        REG_FIELD_SEP   = 2'd0,
        REG_COMMAND_SEP = 2'd1,
        REG_DROP_NL     = 2'd2,
        REG_HANDLER     = 2'd3
    } t_reg_idx;

    typedef enum logic [3:0] {
        PH_SKIP   = 4'b0001,
        PH_WS     = 4'b0010,
        PH_DIGITS = 4'b0100,
        PH_DONE   = 4'b1000
    } t_phase;

    typedef struct packed {
        t_phase      phase;
        logic [15:0] magnitude;
        logic        negative;
    } t_parse;

    localparam t_parse PARSE_CLEAR = '{phase: PH_SKIP, magnitude: 16'd0, negative: 1'b0};

endpackage
`default_nettype wire

// ===== hw/rtl/scfp_parse.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// scfp_parse
// Next-state logic of the on-the-fly token parser for one data byte.
// ---------------------------------------------------------------------------
module scfp_parse
    import scfp_pkg::*;
(
    input  wire logic [7:0] i_byte,
    input  wire logic [7:0] i_field_sep,
    input  wire t_parse     i_cur,
    output t_parse          o_next
);

    logic        sep;
    logic        is_ws;
    logic        is_digit;
    logic [3:0]  digit;
    logic [19:0] acc;
    logic [15:0] mag_add;

    always_comb begin
        sep      = (i_byte == i_field_sep);
        is_ws    = (i_byte == CHAR_SPACE) || (i_byte inside {[CHAR_TAB:CHAR_CR]});
        is_digit = i_byte inside {[CHAR_ZERO:CHAR_NINE]};
        digit    = 4'(i_byte - CHAR_ZERO);
        acc      = {i_cur.magnitude, 3'b000} + {3'b000, i_cur.magnitude, 1'b0}
                 + {16'd0, digit};
        mag_add  = (acc > {4'd0, MAG_LIMIT}) ? MAG_LIMIT : acc[15:0];

        o_next = i_cur;
        case (i_cur.phase)
            PH_SKIP, PH_WS: begin
                if (i_cur.phase == PH_SKIP && sep) begin
                    o_next.phase = PH_SKIP;
                end else if (sep) begin
                    o_next.phase = PH_DONE;
                end else if (is_ws) begin
                    o_next.phase = PH_WS;
                end else if (i_byte == CHAR_PLUS || i_byte == CHAR_MINUS) begin
                    o_next.negative = (i_byte == CHAR_MINUS);
                    o_next.phase    = PH_DIGITS;
                end else if (is_digit) begin
                    o_next.magnitude = mag_add;
                    o_next.phase     = PH_DIGITS;
                end else begin
                    o_next.phase = PH_DONE;
                end
            end
            PH_DIGITS: begin
                if (!sep && is_digit) begin
                    o_next.magnitude = mag_add;
                end else begin
                    o_next.phase = PH_DONE;
                end
            end
            PH_DONE: begin
                o_next.phase = PH_DONE;
            end
            default: begin
                o_next.phase = PH_DONE;
            end
        endcase
    end

endmodule
`default_nettype wire

// ===== hw/rtl/serial_command_frame_parser.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// serial_command_frame_parser
// Frames serial bytes into commands, parses the leading decimal id of each
// frame and reports the handler selection.
// ---------------------------------------------------------------------------
// A result is valid in the cycle after the command separator transfer of a non-empty frame.
// Throughput: one byte per cycle while the input is not stalled; the parse state updates
// at each accepted byte and a one-entry result register decouples the output channel.
// Input is stalled only while a result is held and the output is stalled.
// Reset: synchronous active-low; control registers return to defaults, frame cleared; result data is not reset.
module serial_command_frame_parser
    import scfp_pkg::*;
#(
    parameter int BUFFER_BYTES = BUFFER_BYTES_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_in_valid,
    output logic                       o_in_stall,
    input  wire logic [7:0]            i_data_byte,
    output logic                       o_out_valid,
    input  wire logic                  i_out_stall,
    output logic signed [15:0]         o_command_id,
    output logic                       o_has_handler,
    output logic [2:0]                 o_handler_index,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [31:0]           pwdata,
    output logic [31:0]                prdata,
    output logic                       pready
);

    localparam int CNT_W = $clog2(BUFFER_BYTES);
    localparam logic [CNT_W:0] CNT_LIMIT = (CNT_W + 1)'(BUFFER_BYTES - 1);

    logic [7:0]       r_field_sep;
    logic [7:0]       r_command_sep;
    logic             r_drop_nl;
    logic [7:0]       r_handler_mask;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    t_parse           r_parse;
    t_parse           n_parse;
    t_parse           parse_step;
    logic             r_out_valid;
    logic             n_out_valid;
    logic [15:0]      r_id;
    logic [15:0]      n_id;
    logic             r_hh;
    logic             n_hh;
    logic [2:0]       r_hi;
    logic [2:0]       n_hi;

    logic             accept;
    logic             emit;
    logic             cfg_wr;
    t_reg_idx         cfg_idx;
    logic [CNT_W:0]   cnt_inc;
    logic [2:0]       id_m1;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = t_reg_idx'(paddr[3:2]);

    always_comb begin
        case (t_reg_idx'(paddr[3:2]))
            REG_FIELD_SEP:   prdata = {24'd0, r_field_sep};
            REG_COMMAND_SEP: prdata = {24'd0, r_command_sep};
            REG_DROP_NL:     prdata = {31'd0, r_drop_nl};
            REG_HANDLER:     prdata = {24'd0, r_handler_mask};
            default:         prdata = 32'd0;
        endcase
    end

    scfp_parse u_parse (
        .i_byte      (i_data_byte),
        .i_field_sep (r_field_sep),
        .i_cur       (r_parse),
        .o_next      (parse_step)
    );

    assign o_in_stall = r_out_valid && i_out_stall;
    assign accept     = i_in_valid && !o_in_stall;
    assign cnt_inc    = {1'b0, r_count} + (CNT_W + 1)'(1);

    always_comb begin
        n_count = r_count;
        n_parse = r_parse;
        emit    = 1'b0;
        n_id    = r_id;
        n_hh    = r_hh;
        n_hi    = r_hi;
        id_m1   = 3'd0;

        if (r_parse.negative) begin
            n_id = 16'(-r_parse.magnitude);
        end else begin
            n_id = (r_parse.magnitude > POS_MAX) ? POS_MAX : r_parse.magnitude;
        end
        id_m1 = 3'(n_id - 16'd1);
        n_hh  = !n_id[15] && (n_id != 16'd0) && (n_id <= 16'(NUM_HANDLERS))
              && r_handler_mask[id_m1];
        n_hi  = n_hh ? id_m1 : 3'd0;

        if (accept && i_data_byte != 8'd0) begin
            if (i_data_byte == r_command_sep) begin
                emit    = (r_count != '0);
                n_count = '0;
                n_parse = PARSE_CLEAR;
            end else begin
                n_parse = parse_step;
                n_count = cnt_inc[CNT_W-1:0];
                if (cnt_inc >= CNT_LIMIT ||
                    (r_drop_nl && i_data_byte != r_field_sep &&
                     (i_data_byte == CHAR_LF || i_data_byte == CHAR_CR))) begin
                    n_count = '0;
                    n_parse = PARSE_CLEAR;
                end
            end
        end

        n_out_valid = emit || (r_out_valid && i_out_stall);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_field_sep    <= FIELD_SEP_RST;
            r_command_sep  <= COMMAND_SEP_RST;
            r_drop_nl      <= 1'b0;
            r_handler_mask <= 8'd0;
            r_count        <= '0;
            r_parse        <= PARSE_CLEAR;
            r_out_valid    <= 1'b0;
        end else begin
            if (cfg_wr) begin
                case (cfg_idx)
                    REG_FIELD_SEP:   r_field_sep    <= pwdata[7:0];
                    REG_COMMAND_SEP: r_command_sep  <= pwdata[7:0];
                    REG_DROP_NL:     r_drop_nl      <= pwdata[0];
                    REG_HANDLER:     r_handler_mask <= pwdata[7:0];
                    default: begin
                    end
                endcase
            end
            r_count     <= n_count;
            r_parse     <= n_parse;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_id <= n_id;
            r_hh <= n_hh;
            r_hi <= n_hi;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_command_id    = r_id;
    assign o_has_handler   = r_hh;
    assign o_handler_index = r_hi;

endmodule
`default_nettype wire

// ===== bench/serial_command_frame_parser_test.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// serial_command_frame_parser_test
// Self-checking bench: drives byte streams through the input channel and
// programs the separators, newline drop and handler mask over APB between
// phases. A cycle-free frame decoder predicts the random command results and the directed rows
// carry typed ones; all are compared field by field against the output channel under random stalls.
// ---------------------------------------------------------------------------
module serial_command_frame_parser_test
    import scfp_pkg::*;
();

    typedef struct packed {
        logic signed [15:0] id;
        logic               has_handler;
        logic [2:0]         index;
    } t_command;

    typedef struct packed {
        logic [7:0] data;
        logic       typed;
        t_command   res;
    } t_row;

    typedef struct packed {
        logic [7:0] field_sep;
        logic [7:0] command_sep;
        logic       drop_nl;
        logic [7:0] mask;
    } t_setting;

    logic                  i_clk           = 1'b0;
    logic                  i_rst_n         = 1'b0;
    logic                  i_in_valid      = 1'b0;
    logic                  o_in_stall;
    logic [7:0]            i_data_byte     = 8'd0;
    logic                  o_out_valid;
    logic                  i_out_stall     = 1'b0;
    logic signed [15:0]    o_command_id;
    logic                  o_has_handler;
    logic [2:0]            o_handler_index;
    logic                  psel            = 1'b0;
    logic                  penable         = 1'b0;
    logic                  pwrite          = 1'b0;
    logic [APB_ADDR_W-1:0] paddr           = '0;
    logic [31:0]           pwdata          = '0;
    logic [31:0]           prdata;
    logic                  pready;

    // typed expectation travelling with the byte in flight
    logic     row_typed  = 1'b0;
    t_command row_result = '0;

    serial_command_frame_parser i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_data_byte     (i_data_byte),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_command_id    (o_command_id),
        .o_has_handler   (o_has_handler),
        .o_handler_index (o_handler_index),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    // decoder copy of the registers and frame state
    logic [7:0]  cfg_field_sep   = FIELD_SEP_RST;
    logic [7:0]  cfg_command_sep = COMMAND_SEP_RST;
    logic        cfg_drop_nl     = 1'b0;
    logic [7:0]  cfg_mask        = 8'd0;
    int unsigned frame_len       = 0;
    t_phase      parse_ph        = PH_SKIP;
    logic [15:0] mag             = 16'd0;
    logic        mag_neg         = 1'b0;

    t_command   pending_commands [$];
    logic [7:0] frame_bytes [$];

    int errors         = 0;
    int bytes_sent     = 0;
    int commands_seen  = 0;
    int settings_used  = 0;
    bit tx_calm        = 1'b0;
    bit rx_calm        = 1'b0;
    int rx_hold        = 0;

    t_row directed_rows [25] = '{
        '{8'h00,           1'b0, '0},
        '{COMMAND_SEP_RST, 1'b0, '0},
        '{"7",             1'b0, '0},
        '{COMMAND_SEP_RST, 1'b1, '{16'sd7, 1'b0, 3'd0}},
        '{CHAR_SPACE,      1'b0, '0},
        '{CHAR_MINUS,      1'b0, '0},
        '{"9",             1'b0, '0},
        '{"9",             1'b0, '0},
        '{"9",             1'b0, '0},
        '{"9",             1'b0, '0},
        '{"9",             1'b0, '0},
        '{COMMAND_SEP_RST, 1'b1, '{16'sh8000, 1'b0, 3'd0}},
        '{CHAR_PLUS,       1'b0, '0},
        '{"4",             1'b0, '0},
        '{"0",             1'b0, '0},
        '{"0",             1'b0, '0},
        '{"0",             1'b0, '0},
        '{"0",             1'b0, '0},
        '{COMMAND_SEP_RST, 1'b1, '{16'sd32767, 1'b0, 3'd0}},
        '{8'hFF,           1'b0, '0},
        '{COMMAND_SEP_RST, 1'b1, '{16'sd0, 1'b0, 3'd0}},
        '{FIELD_SEP_RST,   1'b0, '0},
        '{FIELD_SEP_RST,   1'b0, '0},
        '{"3",             1'b0, '0},
        '{COMMAND_SEP_RST, 1'b1, '{16'sd3, 1'b0, 3'd0}}
    };

    t_setting setting_plan [10] = '{
        '{FIELD_SEP_RST,   COMMAND_SEP_RST, 1'b0, 8'hFF},
        '{CHAR_SPACE,      CHAR_LF,         1'b1, 8'hA5},
        '{8'h00,           COMMAND_SEP_RST, 1'b0, 8'h0F},
        '{"5",             ".",             1'b1, 8'h80},
        '{COMMAND_SEP_RST, COMMAND_SEP_RST, 1'b0, 8'h01},
        '{CHAR_LF,         8'hFF,           1'b1, 8'h3C},
        '{8'hFF,           8'h01,           1'b0, 8'h55},
        '{FIELD_SEP_RST,   8'h00,           1'b0, 8'hFF},
        '{8'h01,           8'hFF,           1'b1, 8'h00},
        '{CHAR_MINUS,      COMMAND_SEP_RST, 1'b1, 8'hFE}
    };

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic void clear_frame();
        frame_len = 0;
        parse_ph  = PH_SKIP;
        mag       = 16'd0;
        mag_neg   = 1'b0;
    endfunction

    function automatic bit is_space(input logic [7:0] c);
        return c == CHAR_SPACE || (c >= CHAR_TAB && c <= CHAR_CR);
    endfunction

    function automatic bit is_digit(input logic [7:0] c);
        return c >= CHAR_ZERO && c <= CHAR_NINE;
    endfunction

    function automatic void push_digit(input logic [7:0] c);
        int v;
        v = int'(mag) * 10 + int'(c) - int'(CHAR_ZERO);
        mag = (v > int'(MAG_LIMIT)) ? MAG_LIMIT : v[15:0];
    endfunction

    function automatic void parse_token(input logic [7:0] c);
        logic sep;
        sep = (c == cfg_field_sep);
        if (parse_ph == PH_SKIP) begin
            if (sep) return;
            parse_ph = PH_WS;
        end
        if (parse_ph == PH_WS) begin
            if (sep) begin
                parse_ph = PH_DONE;
            end else if (!is_space(c)) begin
                if (c == CHAR_PLUS || c == CHAR_MINUS) begin
                    mag_neg  = (c == CHAR_MINUS);
                    parse_ph = PH_DIGITS;
                end else if (is_digit(c)) begin
                    push_digit(c);
                    parse_ph = PH_DIGITS;
                end else begin
                    parse_ph = PH_DONE;
                end
            end
        end else if (parse_ph == PH_DIGITS) begin
            if (!sep && is_digit(c)) push_digit(c);
            else parse_ph = PH_DONE;
        end
    endfunction

    // one accepted byte; returns 1 when it completes a command
    function automatic bit decode_byte(input logic [7:0] c, output t_command r);
        int idv;
        r = '0;
        if (c == 8'd0) return 1'b0;
        if (c == cfg_command_sep) begin
            if (frame_len == 0) begin
                clear_frame();
                return 1'b0;
            end
            if (mag_neg) idv = -int'(mag);
            else idv = (mag > POS_MAX) ? int'(POS_MAX) : int'(mag);
            r.id = idv[15:0];
            if (idv >= 1 && idv <= NUM_HANDLERS && cfg_mask[idv-1]) begin
                r.has_handler = 1'b1;
                r.index       = 3'(idv - 1);
            end
            clear_frame();
            return 1'b1;
        end
        parse_token(c);
        frame_len++;
        if (frame_len >= BUFFER_BYTES_DEF - 1) clear_frame();
        if (cfg_drop_nl && c != cfg_field_sep && (c == CHAR_LF || c == CHAR_CR)) clear_frame();
        return 1'b0;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [7:0] pick_space();
        case ($urandom_range(0, 5))
            0: return CHAR_SPACE;
            1: return CHAR_TAB;
            2: return 8'd11;
            3: return 8'd12;
            4: return CHAR_LF;
            default: return CHAR_CR;
        endcase
    endfunction

    always @(posedge i_clk) begin
        t_command want;
        t_command got;
        bit       done;
        if (i_rst_n && i_in_valid && !o_in_stall) begin
            done = decode_byte(i_data_byte, want);
            if (row_typed) pending_commands.push_back(row_result);
            else if (done) pending_commands.push_back(want);
        end
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_commands.size() == 0) begin
                errors++;
                $display("%0t: unexpected command result, id %0d", $time, o_command_id);
            end else begin
                got = pending_commands.pop_front();
                commands_seen++;
                if (o_command_id !== got.id) begin
                    errors++;
                    $display("%0t: command_id mismatch, expected %0d, got %0d",
                             $time, got.id, o_command_id);
                end
                if (o_has_handler !== got.has_handler) begin
                    errors++;
                    $display("%0t: has_handler mismatch, expected %0b, got %0b",
                             $time, got.has_handler, o_has_handler);
                end
                if (o_handler_index !== got.index) begin
                    errors++;
                    $display("%0t: handler_index mismatch, expected %0d, got %0d",
                             $time, got.index, o_handler_index);
                end
            end
        end
    end

    // output back-pressure
    always @(posedge i_clk) begin
        if ($urandom_range(0, 299) == 0) rx_calm = ($urandom_range(0, 2) == 0);
        if (rx_hold == 0 && !rx_calm && $urandom_range(0, 2) == 0) rx_hold = pick_gap();
        i_out_stall <= (rx_hold != 0);
        if (rx_hold != 0) rx_hold--;
    end

    task automatic send_byte(input logic [7:0] b, input logic typed, input t_command res);
        int gap;
        i_in_valid  <= 1'b1;
        i_data_byte <= b;
        row_typed   <= typed;
        row_result  <= res;
        do @(posedge i_clk); while (o_in_stall);
        if (b != 8'd0) bytes_sent++;
        gap = tx_calm ? 0 : pick_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic settle();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_commands.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_reg_idx idx, input logic [7:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {24'd0, value};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        case (idx)
            REG_FIELD_SEP:   cfg_field_sep   = value;
            REG_COMMAND_SEP: cfg_command_sep = value;
            REG_DROP_NL:     cfg_drop_nl     = value[0];
            REG_HANDLER:     cfg_mask        = value;
            default: ;
        endcase
    endtask

    task automatic apply_setting(input t_setting s);
        settle();
        write_reg(REG_FIELD_SEP, s.field_sep);
        write_reg(REG_COMMAND_SEP, s.command_sep);
        write_reg(REG_DROP_NL, {7'd0, s.drop_nl});
        write_reg(REG_HANDLER, s.mask);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        settings_used++;
    endtask

    // mostly well-formed commands, plus empty frames, overlong frames and noise
    task automatic build_frame();
        int    kind;
        int    v;
        int    n;
        string digits;
        frame_bytes.delete();
        kind = $urandom_range(0, 99);
        if (kind < 70) begin
            repeat ($urandom_range(0, 2)) frame_bytes.push_back(cfg_field_sep);
            repeat ($urandom_range(0, 2)) frame_bytes.push_back(pick_space());
            case ($urandom_range(0, 3))
                0: frame_bytes.push_back(CHAR_PLUS);
                1: frame_bytes.push_back(CHAR_MINUS);
                default: ;
            endcase
            n = $urandom_range(0, 99);
            if (n < 55) v = $urandom_range(0, 9);
            else if (n < 80) v = $urandom_range(10, 999);
            else v = $urandom_range(1000, 9999999);
            if ($urandom_range(0, 9) != 0) begin
                digits = $sformatf("%0d", v);
                for (int k = 0; k < digits.len(); k++) frame_bytes.push_back(digits[k]);
            end
            if ($urandom_range(0, 1) != 0) begin
                frame_bytes.push_back(cfg_field_sep);
                repeat ($urandom_range(0, 6)) frame_bytes.push_back(8'($urandom_range(32, 126)));
            end
            if ($urandom_range(0, 19) == 0)
                frame_bytes.insert($urandom_range(0, frame_bytes.size()),
                                   8'($urandom_range(1, 255)));
            frame_bytes.push_back(cfg_command_sep);
        end else if (kind < 78) begin
            repeat ($urandom_range(50, 75)) frame_bytes.push_back(8'($urandom_range(1, 255)));
            frame_bytes.push_back(cfg_command_sep);
        end else if (kind < 88) begin
            if ($urandom_range(0, 1) != 0) frame_bytes.push_back(cfg_field_sep);
            frame_bytes.push_back(cfg_command_sep);
        end else begin
            repeat ($urandom_range(1, 8)) frame_bytes.push_back(8'($urandom_range(0, 255)));
        end
    endtask

    task automatic run_phase(input int count, input bit pause_midway);
        int sent;
        sent = 0;
        while (sent < count) begin
            build_frame();
            foreach (frame_bytes[k]) send_byte(frame_bytes[k], 1'b0, '0);
            sent += frame_bytes.size();
            if ($urandom_range(0, 15) == 0) tx_calm = !tx_calm;
            if (pause_midway && sent >= count / 2) begin
                settle();
                pause_midway = 1'b0;
            end
        end
    endtask

    initial begin
        t_setting rnd;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        foreach (directed_rows[r])
            send_byte(directed_rows[r].data, directed_rows[r].typed, directed_rows[r].res);
        foreach (setting_plan[p]) begin
            apply_setting(setting_plan[p]);
            run_phase(setting_plan[p].command_sep == 8'h00 ? 40 : 175, p == 1);
        end
        repeat (2) begin
            rnd.field_sep   = 8'($urandom_range(1, 255));
            rnd.command_sep = 8'($urandom_range(1, 255));
            rnd.drop_nl     = 1'($urandom_range(0, 1));
            rnd.mask        = 8'($urandom_range(0, 255));
            apply_setting(rnd);
            run_phase(90, 1'b0);
        end
        settle();
        repeat (8) @(posedge i_clk);
        $display("Sent %0d nonzero bytes under %0d register settings.", bytes_sent,
                 settings_used);
        $display("Compared %0d command results, %0d mismatches.", commands_seen, errors);
        if (errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    initial begin
        #10_000_000;
        $display("Timeout with %0d command results outstanding.", pending_commands.size());
        $display("TEST FAILED");
        $finish;
    end

endmodule
